/* src/tsp_pkg.sv */
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int SPEED_W  = 32;
    localparam int TICK_W   = 16;
    localparam int PROD_W   = SPEED_W + TICK_W;
    localparam int CNT_W    = $clog2(PROD_W);
    localparam int CMD_W    = 2;
    localparam int JOINT_W  = 3;
    localparam int AJ_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_JOINT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT   = 3'd4;

    localparam logic [JOINT_W-1:0] JOINT_LO = 3'd1;
    localparam logic [JOINT_W-1:0] JOINT_HI = 3'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* src/tsp_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module tsp_div
    import tsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [TICK_W-1:0]   divisor,
    output logic [SPEED_W-1:0]  quotient,
    output div_status_t         stat
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [TICK_W-1:0] dsr_reg, dsr_next;
    logic [TICK_W:0]   shifted;
    logic [TICK_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PROD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[TICK_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TICK_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // quotient never exceeds the speed magnitude
    assign quotient  = quo_reg[SPEED_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* src/trapezoid_speed_profile_generator.sv */
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    command, system_running, joint, distance,
//                                             duration_ticks, ramp_ticks
// out       output     out_valid / out_ready  speed_ref, status, profile_active,
//                                             profile_done, active_joint
//
// status updates, rejected starts and plain ticks go from decode straight to the result stage
// accepted starts and ramp ticks go through one multiply, then the
// shared restoring divider (one quotient bit per cycle), then a final sign fix
// in_ready is high only while the sequencer is idle; a held result does not block input
// the result register waits for out_ready; a new result stalls until it is taken
// rst_n clears the profile state: not running, no profile, all speeds and counts zero
module trapezoid_speed_profile_generator
    import tsp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic                       system_running,
    input  logic [JOINT_W-1:0]         joint,
    input  logic signed [SPEED_W-1:0]  distance,
    input  logic [TICK_W-1:0]          duration_ticks,
    input  logic [TICK_W-1:0]          ramp_ticks,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SPEED_W-1:0]  speed_ref,
    output logic [STATUS_W-1:0]        status,
    output logic                       profile_active,
    output logic                       profile_done,
    output logic [AJ_W-1:0]            active_joint
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam logic [1:0] JOB_START = 2'd0;
    localparam logic [1:0] JOB_RAMP  = 2'd1;
    localparam logic [1:0] JOB_BRAKE = 2'd2;

    function automatic logic [SPEED_W-1:0] magnitude(input logic signed [SPEED_W-1:0] x);
        logic [SPEED_W-1:0] m;
        m = x[SPEED_W-1] ? (~x + SPEED_W'(1)) : x;
        return m;
    endfunction

    logic [2:0]                 state_reg, state_next;

    // latched transaction
    logic [CMD_W-1:0]           cmd_reg;
    logic                       run_in_reg;
    logic [JOINT_W-1:0]         joint_in_reg;
    logic signed [SPEED_W-1:0]  dist_reg;
    logic [TICK_W-1:0]          dur_reg;
    logic [TICK_W-1:0]          rin_reg;

    // profile state
    logic                       running_reg, running_next;
    logic                       active_reg, active_next;
    logic                       braking_reg, braking_next;
    logic [TICK_W-1:0]          tick_count_reg, tick_count_next;
    logic signed [SPEED_W-1:0]  cruise_reg, cruise_next;
    logic signed [SPEED_W-1:0]  start_speed_reg, start_speed_next;
    logic [TICK_W-1:0]          total_reg, total_next;
    logic [TICK_W-1:0]          ramp_reg, ramp_next;
    logic [AJ_W-1:0]            held_joint_reg, held_joint_next;

    // operands for the shared multiply and divide
    logic [SPEED_W-1:0]         op_a_reg, op_a_next;
    logic [TICK_W-1:0]          op_b_reg, op_b_next;
    logic [TICK_W-1:0]          den_reg, den_next;
    logic                       neg_reg, neg_next;
    logic [1:0]                 job_reg, job_next;

    // pending result
    logic signed [SPEED_W-1:0]  res_speed_reg, res_speed_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                       res_active_reg, res_active_next;
    logic                       res_done_reg, res_done_next;
    logic [AJ_W-1:0]            res_joint_reg, res_joint_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0]  speed_ref_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic                       profile_active_reg;
    logic                       profile_done_reg;
    logic [AJ_W-1:0]            active_joint_reg;
    logic                       out_load;

    logic                       div_start;
    logic [PROD_W-1:0]          div_dividend;
    logic [SPEED_W-1:0]         div_quot;
    div_status_t                div_stat;

    logic                       in_fire;
    logic [TICK_W:0]            t_ext;
    logic [TICK_W-1:0]          dmr;
    logic signed [SPEED_W-1:0]  brake_base;
    logic [SPEED_W:0]           quot_signed;
    logic [SPEED_W:0]           brake_diff;

    assign in_ready = (state_reg == S_IDLE) && !div_stat.busy;
    assign in_fire  = in_valid && in_ready;

    assign t_ext      = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign dmr        = total_reg - ramp_reg;
    assign brake_base = braking_reg ? start_speed_reg : cruise_reg;

    assign quot_signed = neg_reg ? (~{1'b0, div_quot} + (SPEED_W+1)'(1)) : {1'b0, div_quot};
    assign brake_diff  = {start_speed_reg[SPEED_W-1], start_speed_reg} - quot_signed;

    // product of magnitude and tick fraction numerator, captured by the divider
    assign div_start    = (state_reg == S_MUL);
    assign div_dividend = PROD_W'(op_a_reg) * PROD_W'(op_b_reg);

    tsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        running_next     = running_reg;
        active_next      = active_reg;
        braking_next     = braking_reg;
        tick_count_next  = tick_count_reg;
        cruise_next      = cruise_reg;
        start_speed_next = start_speed_reg;
        total_next       = total_reg;
        ramp_next        = ramp_reg;
        held_joint_next  = held_joint_reg;
        op_a_next        = op_a_reg;
        op_b_next        = op_b_reg;
        den_next         = den_reg;
        neg_next         = neg_reg;
        job_next         = job_reg;
        res_speed_next   = res_speed_reg;
        res_status_next  = res_status_reg;
        res_active_next  = res_active_reg;
        res_done_next    = res_done_reg;
        res_joint_next   = res_joint_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next      = S_EMIT;
                res_speed_next  = '0;
                res_status_next = ST_NONE;
                res_done_next   = 1'b0;
                res_active_next = active_reg;
                res_joint_next  = active_reg ? held_joint_reg : '0;
                if (cmd_reg == CMD_STATUS)
                begin
                    running_next = run_in_reg;
                end
                else if (cmd_reg == CMD_START)
                begin
                    if (!running_reg)
                    begin
                        res_status_next = ST_NOT_RUNNING;
                    end
                    else if ((joint_in_reg < JOINT_LO) || (joint_in_reg > JOINT_HI))
                    begin
                        res_status_next = ST_BAD_JOINT;
                    end
                    else if ({1'b0, dur_reg} <= {rin_reg, 1'b0})
                    begin
                        res_status_next = ST_TOO_SHORT;
                    end
                    else
                    begin
                        res_status_next  = ST_ACCEPTED;
                        res_active_next  = 1'b1;
                        res_joint_next   = joint_in_reg[AJ_W-1:0];
                        start_speed_next = '0;
                        total_next       = dur_reg;
                        ramp_next        = rin_reg;
                        tick_count_next  = '0;
                        braking_next     = 1'b0;
                        held_joint_next  = joint_in_reg[AJ_W-1:0];
                        active_next      = 1'b1;
                        op_a_next        = magnitude(dist_reg);
                        op_b_next        = TICK_W'(1);
                        den_next         = dur_reg - rin_reg;
                        neg_next         = dist_reg[SPEED_W-1];
                        job_next         = JOB_START;
                        state_next       = S_MUL;
                    end
                end
                else if ((cmd_reg == CMD_TICK) && active_reg)
                begin
                    tick_count_next = t_ext[TICK_W-1:0];
                    res_joint_next  = held_joint_reg;
                    if ((ramp_reg != '0) && (t_ext <= {1'b0, ramp_reg}))
                    begin
                        // ramp up from zero
                        op_a_next  = magnitude(cruise_reg);
                        op_b_next  = t_ext[TICK_W-1:0];
                        den_next   = ramp_reg;
                        neg_next   = cruise_reg[SPEED_W-1];
                        job_next   = JOB_RAMP;
                        state_next = S_MUL;
                    end
                    else if ((t_ext > {1'b0, ramp_reg}) && (t_ext < {1'b0, dmr}))
                    begin
                        res_speed_next = cruise_reg;
                    end
                    else if ((ramp_reg != '0) && (t_ext >= {1'b0, dmr})
                             && (t_ext < {1'b0, total_reg}))
                    begin
                        // first braking tick moves the cruise speed over
                        if (!braking_reg)
                        begin
                            start_speed_next = cruise_reg;
                            cruise_next      = '0;
                            braking_next     = 1'b1;
                        end
                        op_a_next  = magnitude(brake_base);
                        op_b_next  = TICK_W'(t_ext - {1'b0, dmr});
                        den_next   = ramp_reg;
                        neg_next   = brake_base[SPEED_W-1];
                        job_next   = JOB_BRAKE;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_done_next   = 1'b1;
                        res_active_next = 1'b0;
                        active_next     = 1'b0;
                        held_joint_next = '0;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_EMIT;
                unique case (job_reg)
                    JOB_START: cruise_next    = quot_signed[SPEED_W-1:0];
                    JOB_RAMP:  res_speed_next = quot_signed[SPEED_W-1:0];
                    JOB_BRAKE: res_speed_next = brake_diff[SPEED_W-1:0];
                    default:   res_speed_next = '0;
                endcase
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            running_reg     <= 1'b0;
            active_reg      <= 1'b0;
            braking_reg     <= 1'b0;
            tick_count_reg  <= '0;
            cruise_reg      <= '0;
            start_speed_reg <= '0;
            total_reg       <= '0;
            ramp_reg        <= '0;
            held_joint_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            running_reg     <= running_next;
            active_reg      <= active_next;
            braking_reg     <= braking_next;
            tick_count_reg  <= tick_count_next;
            cruise_reg      <= cruise_next;
            start_speed_reg <= start_speed_next;
            total_reg       <= total_next;
            ramp_reg        <= ramp_next;
            held_joint_reg  <= held_joint_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg      <= command;
            run_in_reg   <= system_running;
            joint_in_reg <= joint;
            dist_reg     <= distance;
            dur_reg      <= duration_ticks;
            rin_reg      <= ramp_ticks;
        end
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        job_reg        <= job_next;
        res_speed_reg  <= res_speed_next;
        res_status_reg <= res_status_next;
        res_active_reg <= res_active_next;
        res_done_reg   <= res_done_next;
        res_joint_reg  <= res_joint_next;
        if (out_load)
        begin
            speed_ref_reg      <= res_speed_reg;
            status_reg         <= res_status_reg;
            profile_active_reg <= res_active_reg;
            profile_done_reg   <= res_done_reg;
            active_joint_reg   <= res_joint_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign speed_ref      = speed_ref_reg;
    assign status         = status_reg;
    assign profile_active = profile_active_reg;
    assign profile_done   = profile_done_reg;
    assign active_joint   = active_joint_reg;

endmodule

/* verif/tb_trapezoid_speed_profile_generator.sv */
`timescale 1ns / 1ps

module tb_trapezoid_speed_profile_generator;
    import tsp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 125;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_TAIL  = 64;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic                      run;
        logic [JOINT_W-1:0]        jnt;
        logic signed [SPEED_W-1:0] move_dist;
        logic [TICK_W-1:0]         dur;
        logic [TICK_W-1:0]         ramp;
    } motion_req_t;

    typedef struct {
        logic signed [SPEED_W-1:0] speed;
        logic [STATUS_W-1:0]       st;
        logic                      active;
        logic                      done;
        logic [AJ_W-1:0]           aj;
    } speed_sample_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          command = CMD_TICK;
    logic                      system_running = 1'b0;
    logic [JOINT_W-1:0]        joint = '0;
    logic signed [SPEED_W-1:0] distance = '0;
    logic [TICK_W-1:0]         duration_ticks = '0;
    logic [TICK_W-1:0]         ramp_ticks = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [SPEED_W-1:0] speed_ref;
    logic [STATUS_W-1:0]       status;
    logic                      profile_active;
    logic                      profile_done;
    logic [AJ_W-1:0]           active_joint;

    motion_req_t   pending_reqs[$];
    speed_sample_t expected_speeds[$];
    motion_req_t   cur_req;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int queued_items  = 0;
    logic stim_running = 1'b0;

    // predicted generator state
    logic                      sys_running = 1'b0;
    logic                      prof_active = 1'b0;
    logic                      prof_braking = 1'b0;
    logic [TICK_W-1:0]         prof_tick = '0;
    logic signed [SPEED_W-1:0] prof_cruise = '0;
    logic signed [SPEED_W-1:0] prof_start = '0;
    logic [TICK_W-1:0]         prof_total = '0;
    logic [TICK_W-1:0]         prof_ramp = '0;
    logic [AJ_W-1:0]           prof_joint = '0;

    trapezoid_speed_profile_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .system_running (system_running),
        .joint          (joint),
        .distance       (distance),
        .duration_ticks (duration_ticks),
        .ramp_ticks     (ramp_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speed_ref      (speed_ref),
        .status         (status),
        .profile_active (profile_active),
        .profile_done   (profile_done),
        .active_joint   (active_joint)
    );

    always #5 clk = ~clk;

    // trunc(num * v / den) toward zero, split to keep the product small
    function automatic longint ramp_fraction(input longint v, input longint num,
                                             input longint den);
        longint m;
        longint q;
        longint rem;
        longint res;
        m = (v < 0) ? -v : v;
        q = m / den;
        rem = m % den;
        res = num * q + (num * rem) / den;
        return (v < 0) ? -res : res;
    endfunction

    function automatic speed_sample_t profile_step(input motion_req_t r);
        speed_sample_t o;
        longint t;
        longint d;
        longint rr;
        longint dist_l;
        o.speed = '0;
        o.st = ST_NONE;
        o.done = 1'b0;
        o.aj = prof_active ? prof_joint : '0;
        case (r.cmd)
            CMD_STATUS: sys_running = r.run;
            CMD_START:
            begin
                d = longint'(r.dur);
                rr = longint'(r.ramp);
                if (!sys_running)
                    o.st = ST_NOT_RUNNING;
                else if (r.jnt < JOINT_LO || r.jnt > JOINT_HI)
                    o.st = ST_BAD_JOINT;
                else if (d <= 2 * rr)
                    o.st = ST_TOO_SHORT;
                else
                begin
                    dist_l = longint'(r.move_dist);
                    prof_cruise = SPEED_W'(dist_l / (d - rr));
                    prof_start = '0;
                    prof_total = r.dur;
                    prof_ramp = r.ramp;
                    prof_tick = '0;
                    prof_braking = 1'b0;
                    prof_joint = r.jnt[AJ_W-1:0];
                    prof_active = 1'b1;
                    o.st = ST_ACCEPTED;
                    o.aj = r.jnt[AJ_W-1:0];
                end
            end
            CMD_TICK:
            begin
                if (prof_active)
                begin
                    t = longint'(prof_tick) + 1;
                    d = longint'(prof_total);
                    rr = longint'(prof_ramp);
                    prof_tick = t[TICK_W-1:0];
                    o.aj = prof_joint;
                    if (rr != 0 && t <= rr)
                        o.speed = SPEED_W'(ramp_fraction(longint'(prof_cruise), t, rr));
                    else if (t > rr && t < d - rr)
                        o.speed = prof_cruise;
                    else if (rr != 0 && t >= d - rr && t < d)
                    begin
                        // first tick of the ramp down latches the cruise speed
                        if (!prof_braking)
                        begin
                            prof_start = prof_cruise;
                            prof_cruise = '0;
                            prof_braking = 1'b1;
                        end
                        o.speed = SPEED_W'(longint'(prof_start)
                                  - ramp_fraction(longint'(prof_start), t - (d - rr), rr));
                    end
                    else
                    begin
                        o.done = 1'b1;
                        prof_active = 1'b0;
                        prof_joint = '0;
                    end
                end
            end
            default: ;
        endcase
        o.active = prof_active;
        return o;
    endfunction

    // driver: offer the next pending request once the current one is taken
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_speeds.push_back(profile_step(cur_req));
        if (!in_valid || in_ready)
        begin
            if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_req = pending_reqs.pop_front();
                command <= cur_req.cmd;
                system_running <= cur_req.run;
                joint <= cur_req.jnt;
                distance <= cur_req.move_dist;
                duration_ticks <= cur_req.dur;
                ramp_ticks <= cur_req.ramp;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver backpressure, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        speed_sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                $error("unexpected result: speed_ref %0d status %0d", speed_ref, status);
                mismatches++;
            end
            else
            begin
                want = expected_speeds.pop_front();
                if (speed_ref !== want.speed)
                begin
                    $error("speed_ref: expected %0d, got %0d", want.speed, speed_ref);
                    mismatches++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatches++;
                end
                if (profile_active !== want.active)
                begin
                    $error("profile_active: expected %0b, got %0b", want.active,
                           profile_active);
                    mismatches++;
                end
                if (profile_done !== want.done)
                begin
                    $error("profile_done: expected %0b, got %0b", want.done, profile_done);
                    mismatches++;
                end
                if (active_joint !== want.aj)
                begin
                    $error("active_joint: expected %0d, got %0d", want.aj, active_joint);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("trapezoid_speed_profile_generator regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_req(input logic [CMD_W-1:0] c, input logic run,
                             input logic [JOINT_W-1:0] j,
                             input logic signed [SPEED_W-1:0] move_d,
                             input logic [TICK_W-1:0] dur, input logic [TICK_W-1:0] rmp);
        motion_req_t r;
        r.cmd = c;
        r.run = run;
        r.jnt = j;
        r.move_dist = move_d;
        r.dur = dur;
        r.ramp = rmp;
        if (c == CMD_STATUS)
            stim_running = run;
        pending_reqs.push_back(r);
        queued_items++;
    endtask

    // unused fields carry random junk
    task automatic queue_tick();
        queue_req(CMD_TICK, 1'($urandom), JOINT_W'($urandom), SPEED_W'($urandom),
                  TICK_W'($urandom), TICK_W'($urandom));
    endtask

    task automatic queue_status(input logic run);
        queue_req(CMD_STATUS, run, JOINT_W'($urandom), SPEED_W'($urandom),
                  TICK_W'($urandom), TICK_W'($urandom));
    endtask

    function automatic logic signed [SPEED_W-1:0] rand_dist();
        logic signed [SPEED_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1:
            begin
                v = $urandom_range(3276800);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // well-formed start followed by enough ticks to finish, with some interference
    task automatic run_profile();
        int dur;
        int rmp;
        int n;
        int k;
        int bad_r;
        if (!stim_running || $urandom_range(5) == 0)
            queue_status(1'b1);
        dur = ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        rmp = $urandom_range((dur - 1) / 2);
        queue_req(CMD_START, 1'($urandom), JOINT_W'($urandom_range(JOINT_HI, JOINT_LO)),
                  rand_dist(), TICK_W'(dur), TICK_W'(rmp));
        n = dur + $urandom_range(2);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(29))
                0: queue_status(1'b1);
                1: queue_req(CMD_START, 1'($urandom),
                             $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 4)),
                             rand_dist(), TICK_W'(dur), TICK_W'(rmp));
                2:
                begin
                    bad_r = $urandom_range(300, 1);
                    queue_req(CMD_START, 1'($urandom),
                              JOINT_W'($urandom_range(JOINT_HI, JOINT_LO)),
                              rand_dist(), TICK_W'($urandom_range(2 * bad_r)),
                              TICK_W'(bad_r));
                end
                3:
                begin
                    queue_status(1'b0);
                    queue_req(CMD_START, 1'($urandom),
                              JOINT_W'($urandom_range(JOINT_HI, JOINT_LO)),
                              rand_dist(), TICK_W'(dur), TICK_W'(rmp));
                    queue_status(1'b1);
                end
                default: queue_tick();
            endcase
        end
    endtask

    task automatic random_phase();
        int first;
        int k;
        int burst;
        first = queued_items;
        while (queued_items - first < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 85)
                run_profile();
            else
            begin
                burst = $urandom_range(4, 1);
                for (k = 0; k < burst; k++)
                    queue_req(($urandom_range(19) == 0) ? CMD_UNUSED
                                                        : CMD_W'($urandom_range(2)),
                              1'($urandom), JOINT_W'($urandom), SPEED_W'($urandom),
                              TICK_W'($urandom), TICK_W'($urandom));
            end
        end
    endtask

    // sender waits until every transaction has come back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_reqs.size() > 0 || in_valid || expected_speeds.size() > 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_tick();
        queue_req(CMD_START, 1'b0, 3'd1, 32'sd65536, 16'd10, 16'd2);
        queue_req(CMD_UNUSED, 1'b1, 3'd7, -32'sd1, 16'hFFFF, 16'hFFFF);
        queue_status(1'b1);
        queue_req(CMD_START, 1'b1, 3'd0, 32'sd65536, 16'd10, 16'd2);
        queue_req(CMD_START, 1'b0, 3'd7, 32'sd65536, 16'd10, 16'd2);
        queue_req(CMD_START, 1'b1, 3'd2, 32'sd65536, 16'd8, 16'd4);
        queue_req(CMD_START, 1'b0, 3'd2, 32'sd65536, 16'd0, 16'd0);
        queue_req(CMD_START, 1'b1, 3'd3, 32'sh7FFFFFFF, 16'd5, 16'd2);
        queue_tick();
        queue_tick();
        // stop the system mid-profile; a rejected start must not disturb it
        queue_status(1'b0);
        queue_req(CMD_START, 1'b1, 3'd1, 32'sd100, 16'd10, 16'd1);
        queue_status(1'b1);
        queue_tick();
        queue_tick();
        queue_tick();
        // zero ramp, then restarts while active
        queue_req(CMD_START, 1'b0, 3'd1, 32'sh80000000, 16'd3, 16'd0);
        queue_tick();
        queue_req(CMD_START, 1'b1, 3'd2, 32'sh80000000, 16'hFFFF, 16'h7FFF);
        queue_tick();
        queue_tick();
        queue_req(CMD_START, 1'b0, 3'd1, 32'sh80000000, 16'd1, 16'd0);
        queue_tick();
        queue_req(CMD_START, 1'b1, 3'd3, 32'sd0, 16'd2, 16'd0);
        queue_tick();
        queue_tick();
        drain();

        set_idling(0, 0);
        random_phase();
        hold_cycles = HOLD_LEN;
        drain();

        set_idling(86, 0);
        random_phase();
        drain();

        set_idling(0, 86);
        random_phase();
        drain();

        set_idling(12, 12);
        random_phase();
        drain();

        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && expected_speeds.size() == 0)
            $display("trapezoid_speed_profile_generator regression: pass");
        else
            $display("trapezoid_speed_profile_generator regression: fail");
        $finish;
    end

endmodule
